>>> design/nlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nlt_pkg;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // most expiries reported for one tick
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] HELLO_TYPE = 8'd2;
    localparam logic [7:0] HELLO_TTL  = 8'd1;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HELLO_LENGTH = 2'd2;

    localparam logic [ADDR_W-1:0]  OWN_ADDRESS_RST  = 32'd0;
    localparam logic [COUNT_W-1:0] HOLD_TICKS_RST   = 16'd2000;
    localparam logic [15:0]        HELLO_LENGTH_RST = 16'd48;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] source_address;
        logic [7:0]        time_to_live;
        logic [15:0]       packet_length;
        logic [7:0]        message_type;
        logic [ADDR_W-1:0] originator_address;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] neighbour_address;
        logic              inserted;
        logic              refreshed;
        logic              table_full;
        logic              last;
    } t_out;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_INSERT,
        CMD_REFRESH,
        CMD_REPORT,
        CMD_AGE,
        CMD_FLUSH
    } t_cmd;

    typedef struct packed {
        logic in_tick;
        logic in_own;
        logic last_slot;
        logic age_wait;
        logic out_free;
        logic pend_valid;
    } t_stat;

endpackage

`default_nettype wire

>>> design/nlt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/nlt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nlt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire nlt_pkg::t_stat i_stat,
    output nlt_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PKT_READ,
        S_PKT_SCAN,
        S_PKT_INSERT,
        S_PKT_REFRESH,
        S_PKT_REPORT,
        S_TICK_READ,
        S_TICK_AGE,
        S_TICK_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = nlt_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = nlt_pkg::CMD_LOAD;
                    if (i_stat.in_tick) begin
                        n_state = S_TICK_READ;
                    end else if (i_stat.in_own) begin
                        n_state = S_PKT_REPORT;
                    end else begin
                        n_state = S_PKT_READ;
                    end
                end
            end
            S_PKT_READ: begin
                n_state = S_PKT_SCAN;
            end
            S_PKT_SCAN: begin
                o_cmd   = nlt_pkg::CMD_SCAN;
                n_state = i_stat.last_slot ? S_PKT_INSERT : S_PKT_READ;
            end
            S_PKT_INSERT: begin
                o_cmd   = nlt_pkg::CMD_INSERT;
                n_state = S_PKT_REFRESH;
            end
            S_PKT_REFRESH: begin
                o_cmd   = nlt_pkg::CMD_REFRESH;
                n_state = S_PKT_REPORT;
            end
            S_PKT_REPORT: begin
                o_cmd = nlt_pkg::CMD_REPORT;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_READ: begin
                n_state = S_TICK_AGE;
            end
            S_TICK_AGE: begin
                o_cmd = nlt_pkg::CMD_AGE;
                if (!i_stat.age_wait) begin
                    n_state = i_stat.last_slot ? S_TICK_FLUSH : S_TICK_READ;
                end
            end
            S_TICK_FLUSH: begin
                o_cmd = nlt_pkg::CMD_FLUSH;
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

    a_stall_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_stall == (r_state != S_IDLE))
        else $error("input stall out of step with state");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == nlt_pkg::CMD_LOAD) |-> (r_state == S_IDLE && i_in_valid))
        else $error("item loaded outside idle");

    a_scan_ends_in_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PKT_SCAN && i_stat.last_slot) |=> (r_state == S_PKT_INSERT))
        else $error("packet scan did not end in insert step");

endmodule

`default_nettype wire

>>> design/nlt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module nlt_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire nlt_pkg::t_in                     i_in_data,
    input  wire logic                             i_cfg_valid,
    input  wire logic [nlt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nlt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire nlt_pkg::t_cmd                    i_cmd,
    output nlt_pkg::t_stat                        o_stat,
    input  wire logic                             i_out_stall,
    output logic                                  o_out_valid,
    output nlt_pkg::t_out                         o_out_data
);

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [nlt_pkg::ADDR_W-1:0]  r_own_address;
    logic [nlt_pkg::COUNT_W-1:0] r_hold_ticks;
    logic [15:0]                 r_hello_length;

    nlt_pkg::t_in                r_item;
    logic [TABLE_DEPTH-1:0]      r_valid;
    logic [IW-1:0]               r_idx;
    logic                        r_orig_found;
    logic                        r_src_found;
    logic [IW-1:0]               r_src_idx;
    logic                        r_free_found;
    logic [IW-1:0]               r_free_idx;
    logic                        r_ins;
    logic                        r_full;
    logic [nlt_pkg::CNT_W-1:0]   r_n;
    logic                        r_pend_valid;
    logic [nlt_pkg::ADDR_W-1:0]  r_pend_addr;
    logic                        r_out_valid;
    nlt_pkg::t_out               r_out;

    logic [nlt_pkg::ADDR_W-1:0]  addr_rdata;
    logic [nlt_pkg::COUNT_W-1:0] cd_rdata;
    logic [nlt_pkg::COUNT_W-1:0] cd_dec;
    logic                        cur_valid;
    logic                        last_slot;
    logic                        out_free;
    logic                        hello;
    logic                        do_ins;
    logic                        exp_hit;
    logic                        age_wait;
    logic                        push;
    nlt_pkg::t_out               push_data;
    logic                        addr_we;
    logic                        cd_we;
    logic [IW-1:0]               cd_waddr;
    logic [nlt_pkg::COUNT_W-1:0] cd_wdata;

    assign cur_valid = r_valid[r_idx];
    assign last_slot = (r_idx == IW'(TABLE_DEPTH - 1));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign hello     = (r_item.packet_length == r_hello_length)
                    && (r_item.message_type == nlt_pkg::HELLO_TYPE)
                    && (r_item.time_to_live == nlt_pkg::HELLO_TTL);
    assign do_ins    = hello && !r_orig_found && r_free_found;
    assign cd_dec    = (cd_rdata == '0) ? '0 : cd_rdata - 1'b1;
    // entries past the per-tick report limit stay valid, parked at zero
    assign exp_hit   = cur_valid && (cd_dec == '0)
                    && (r_n < nlt_pkg::CNT_W'(nlt_pkg::MAX_RESULTS));
    // an expiry needs the pending slot emptied into the output register first
    assign age_wait  = exp_hit && r_pend_valid && !out_free;

    always_comb begin
        o_stat.in_tick    = (i_in_data.operation == nlt_pkg::OP_TICK);
        o_stat.in_own     = (i_in_data.source_address == r_own_address);
        o_stat.last_slot  = last_slot;
        o_stat.age_wait   = age_wait;
        o_stat.out_free   = out_free;
        o_stat.pend_valid = r_pend_valid;
    end

    always_comb begin
        push                        = 1'b0;
        push_data.kind              = nlt_pkg::KIND_EXPIRED;
        push_data.neighbour_address = r_pend_addr;
        push_data.inserted          = 1'b0;
        push_data.refreshed         = 1'b0;
        push_data.table_full        = 1'b0;
        push_data.last              = 1'b0;
        case (i_cmd)
            nlt_pkg::CMD_REPORT: begin
                push                        = out_free;
                push_data.kind              = nlt_pkg::KIND_FORWARD;
                push_data.neighbour_address = '0;
                push_data.inserted          = r_ins;
                push_data.refreshed         = r_src_found;
                push_data.table_full        = r_full;
                push_data.last              = 1'b1;
            end
            nlt_pkg::CMD_AGE: begin
                push = exp_hit && r_pend_valid && out_free;
            end
            nlt_pkg::CMD_FLUSH: begin
                push           = r_pend_valid && out_free;
                push_data.last = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_comb begin
        addr_we  = (i_cmd == nlt_pkg::CMD_INSERT) && do_ins;
        cd_we    = 1'b0;
        cd_waddr = r_idx;
        cd_wdata = r_hold_ticks;
        case (i_cmd)
            nlt_pkg::CMD_INSERT: begin
                cd_we    = do_ins;
                cd_waddr = r_free_idx;
            end
            nlt_pkg::CMD_REFRESH: begin
                cd_we    = r_src_found;
                cd_waddr = r_src_idx;
            end
            nlt_pkg::CMD_AGE: begin
                cd_we    = cur_valid && !age_wait;
                cd_wdata = cd_dec;
            end
            default: begin
                cd_we = 1'b0;
            end
        endcase
    end

    nlt_ram #(
        .WIDTH (nlt_pkg::ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_item.originator_address),
        .i_raddr (r_idx),
        .o_rdata (addr_rdata)
    );

    nlt_ram #(
        .WIDTH (nlt_pkg::COUNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cd_we),
        .i_waddr (cd_waddr),
        .i_wdata (cd_wdata),
        .i_raddr (r_idx),
        .o_rdata (cd_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address  <= nlt_pkg::OWN_ADDRESS_RST;
            r_hold_ticks   <= nlt_pkg::HOLD_TICKS_RST;
            r_hello_length <= nlt_pkg::HELLO_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nlt_pkg::REG_OWN_ADDRESS:  r_own_address  <= i_cfg_data;
                nlt_pkg::REG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data[nlt_pkg::COUNT_W-1:0];
                nlt_pkg::REG_HELLO_LENGTH: r_hello_length <= i_cfg_data[15:0];
                default: begin
                    r_own_address <= r_own_address;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_idx        <= '0;
            r_orig_found <= 1'b0;
            r_src_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_ins        <= 1'b0;
            r_full       <= 1'b0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (i_cmd)
                nlt_pkg::CMD_LOAD: begin
                    r_item       <= i_in_data;
                    r_idx        <= '0;
                    r_orig_found <= 1'b0;
                    r_src_found  <= 1'b0;
                    r_free_found <= 1'b0;
                    r_ins        <= 1'b0;
                    r_full       <= 1'b0;
                    r_n          <= '0;
                    r_pend_valid <= 1'b0;
                end
                nlt_pkg::CMD_SCAN: begin
                    if (cur_valid && addr_rdata == r_item.originator_address) begin
                        r_orig_found <= 1'b1;
                    end
                    if (cur_valid && addr_rdata == r_item.source_address) begin
                        r_src_found <= 1'b1;
                        r_src_idx   <= r_idx;
                    end
                    if (!cur_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_idx;
                    end
                    if (!last_slot) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                nlt_pkg::CMD_INSERT: begin
                    if (do_ins) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_ins               <= 1'b1;
                        // hello from its own source refreshes the new entry
                        if (r_item.originator_address == r_item.source_address) begin
                            r_src_found <= 1'b1;
                            r_src_idx   <= r_free_idx;
                        end
                    end
                    if (hello && !r_orig_found && !r_free_found) begin
                        r_full <= 1'b1;
                    end
                end
                nlt_pkg::CMD_AGE: begin
                    if (!age_wait) begin
                        if (exp_hit) begin
                            r_valid[r_idx] <= 1'b0;
                            r_n            <= r_n + 1'b1;
                            r_pend_valid   <= 1'b1;
                            r_pend_addr    <= addr_rdata;
                        end
                        if (!last_slot) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                nlt_pkg::CMD_FLUSH: begin
                    if (out_free) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase

            if (push) begin
                r_out_valid <= 1'b1;
                r_out       <= push_data;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_report_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= nlt_pkg::CNT_W'(nlt_pkg::MAX_RESULTS))
        else $error("more expiries than the per-tick limit");

    a_no_pending_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == nlt_pkg::CMD_LOAD) |-> !r_pend_valid)
        else $error("expiry left pending at new item");

    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == nlt_pkg::CMD_INSERT && do_ins) |-> !r_valid[r_free_idx])
        else $error("insert into a live slot");

    a_ins_full_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ins && r_full))
        else $error("insert and table full both flagged");

endmodule

`default_nettype wire

>>> design/neighbor_liveness_timeout_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// neighbor liveness table: live neighbours with a countdown each.
// input channel (i_in_valid / o_in_stall, i_in_data) takes a packet or a tick.
// a packet from another node is matched against the table, may insert its
// originator when it is a hello, and reloads its source's countdown if held; it
// gives one result with last set. a tick ages every entry and reports each
// entry that runs out (up to 16 per tick, lowest slot first), the final one
// with last set; a tick with no expiry gives no result.
// the table sits in two single-port-write rams, scanned one slot at a time
// (read, then compare or age). a packet steps through the scan, then insert,
// refresh and report; an own packet goes straight to its report step; a tick
// ends with a flush step. o_in_stall is high while an item is busy.
// results leave through a one-entry output register; while the receiver
// stalls, a tick scan holds at the next expiry once one result is parked
// behind the register and a packet waits at its report step.
// synchronous active-low reset clears valid bits, flags and control state.
// configuration writes (i_cfg_valid, o_cfg_ready) are always taken; index 3
// is ignored; write only while the block is idle.
module neighbor_liveness_timeout_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire nlt_pkg::t_in                    i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output nlt_pkg::t_out                        o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [nlt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [nlt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    nlt_pkg::t_cmd  cmd;
    nlt_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    nlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nlt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
